>>> rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising edge outside reset.
`define WSD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define WSD_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define WSD_ASSERT(label, clk, rst_n, prop, msg)
`define WSD_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/wsd_pkg.sv
// Types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsd_pkg;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_HDR1 = 5'b00001,
        PH_HDR2 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Byte counts of the extended length fields and of the masking key.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Byte held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } step_t;

    // One parsed result, with its valid flag.
    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       has_data;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic       frame_end;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/wsd_in_reg.sv
// Input register of the deframer: holds one received byte until it is parsed.
// Depends on wsd_pkg.
`default_nettype none

module wsd_in_reg
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       adv,
    output step_t           step
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    // The register frees up whenever its byte moves on to the parser.
    assign in_stall = valid_reg && !adv;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx_byte;
        end
    end

    assign step.valid = valid_reg;
    assign step.data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/wsd_parser.sv
// Frame parser: header, extended length and key state, payload unmasking.
// Depends on wsd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic [7:0] data,
    output result_t         res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic        fin_reg;
    logic        fin_next;
    logic [3:0]  opcode_reg;
    logic [3:0]  opcode_next;
    logic        masked_reg;
    logic        masked_next;
    logic [3:0]  ext_left_reg;
    logic [3:0]  ext_left_next;
    logic [63:0] payload_left_reg;
    logic [63:0] payload_left_next;
    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [1:0]  key_index_reg;
    logic [1:0]  key_index_next;
    logic [7:0]  key_byte;
    logic [63:0] length_done;
    logic        length_ready;

    // Key byte for the current payload position; the first key byte is on top.
    always_comb
    begin
        case (key_index_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next state and result for the byte in the input register.
    always_comb
    begin
        phase_next        = phase_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        masked_next       = masked_reg;
        ext_left_next     = ext_left_reg;
        payload_left_next = payload_left_reg;
        key_next          = key_reg;
        key_index_next    = key_index_reg;
        length_done       = '0;
        length_ready      = 1'b0;

        res.valid          = 1'b0;
        res.payload_byte   = 8'd0;
        res.has_data       = 1'b0;
        res.frame_opcode   = opcode_reg;
        res.final_fragment = fin_reg;
        res.frame_end      = 1'b0;

        case (phase_reg)
            PH_HDR2:
            begin
                masked_next       = data[7];
                payload_left_next = '0;
                if (data[6:0] == LEN_EXT16)
                begin
                    ext_left_next = EXT16_BYTES;
                    phase_next    = PH_EXT;
                end
                else if (data[6:0] == LEN_EXT64)
                begin
                    ext_left_next = EXT64_BYTES;
                    phase_next    = PH_EXT;
                end
                else
                begin
                    payload_left_next = {57'd0, data[6:0]};
                    length_done       = {57'd0, data[6:0]};
                    length_ready      = 1'b1;
                end
            end
            PH_EXT:
            begin
                payload_left_next = {payload_left_reg[55:0], data};
                ext_left_next     = ext_left_reg - 4'd1;
                length_done       = {payload_left_reg[55:0], data};
                length_ready      = (ext_left_next == 4'd0);
            end
            PH_KEY:
            begin
                key_next      = {key_reg[23:0], data};
                ext_left_next = ext_left_reg - 4'd1;
                if (ext_left_next == 4'd0)
                begin
                    key_index_next = 2'd0;
                    if (payload_left_reg == 64'd0)
                    begin
                        res.valid     = 1'b1;
                        res.frame_end = 1'b1;
                        phase_next    = PH_HDR1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                key_index_next    = key_index_reg + 2'd1;
                payload_left_next = payload_left_reg - 64'd1;
                res.valid         = 1'b1;
                res.has_data      = 1'b1;
                res.payload_byte  = masked_reg ? (data ^ key_byte) : data;
                res.frame_end     = (payload_left_next == 64'd0);
                if (payload_left_next == 64'd0)
                begin
                    phase_next = PH_HDR1;
                end
            end
            default:
            begin
                // First header byte; unknown phase codes land here as well.
                fin_next    = data[7];
                opcode_next = data[3:0];
                phase_next  = PH_HDR2;
            end
        endcase

        // Length complete: collect the key, close an empty frame or start data.
        if (length_ready)
        begin
            if (masked_next)
            begin
                ext_left_next = KEY_BYTES;
                key_next      = '0;
                phase_next    = PH_KEY;
            end
            else if (length_done == 64'd0)
            begin
                res.valid     = 1'b1;
                res.frame_end = 1'b1;
                phase_next    = PH_HDR1;
            end
            else
            begin
                key_index_next = 2'd0;
                phase_next     = PH_DATA;
            end
        end

        res.valid = res.valid && adv;
    end

    // State advances only when a byte is taken from the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR1;
            fin_reg          <= 1'b0;
            opcode_reg       <= 4'd0;
            masked_reg       <= 1'b0;
            ext_left_reg     <= 4'd0;
            payload_left_reg <= 64'd0;
            key_reg          <= 32'd0;
            key_index_reg    <= 2'd0;
        end
        else if (adv)
        begin
            phase_reg        <= phase_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            masked_reg       <= masked_next;
            ext_left_reg     <= ext_left_next;
            payload_left_reg <= payload_left_next;
            key_reg          <= key_next;
            key_index_reg    <= key_index_next;
        end
    end

    // A data phase always has at least one byte still to come.
    `WSD_ASSERT(a_data_left, clk, rst_n, (phase_reg == PH_DATA) |-> (payload_left_reg != 64'd0), "data phase with no payload left")
    // Extended length counter stays within one to eight bytes.
    `WSD_ASSERT(a_ext_range, clk, rst_n, (phase_reg == PH_EXT) |-> ((ext_left_reg != 4'd0) && (ext_left_reg <= EXT64_BYTES)), "extended length count out of range")
    // Key counter stays within one to four bytes.
    `WSD_ASSERT(a_key_range, clk, rst_n, (phase_reg == PH_KEY) |-> ((ext_left_reg != 4'd0) && (ext_left_reg <= KEY_BYTES)), "key byte count out of range")
    // An empty-frame marker always closes its frame.
    `WSD_NEVER(a_empty_end, clk, rst_n, res.valid && !res.has_data && !res.frame_end, "empty marker without frame end")

endmodule

`default_nettype wire

>>> rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_in_reg, wsd_parser and assert_macros.svh.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  rx_byte
//   out      out_valid / out_stall payload_byte, has_data, frame_opcode,
//                                  final_fragment, frame_end
//
// One byte is taken per clock while in_stall is low; it passes the input, then the result register.
// The parser state and the result register advance together, one byte per cycle while not stalled.
// Header, extended length and key bytes give no result; a payload byte or an empty frame gives one.
// Reset clears all parser state; the parser then expects the first header byte.
// A held result stalls the input only while out_stall is high.
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      payload_byte,
    output logic            has_data,
    output logic [3:0]      frame_opcode,
    output logic            final_fragment,
    output logic            frame_end
);

    step_t   step;
    result_t res;
    logic    adv;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    // The held byte moves on when the result register is free or being emptied.
    assign adv = step.valid && (!out_valid_reg || !out_stall);

    wsd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .adv      (adv),
        .step     (step)
    );

    wsd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .data  (step.data),
        .res   (res)
    );

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = res.valid;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload loads only with a new result.
    always_ff @(posedge clk)
    begin
        if (adv && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = out_reg.payload_byte;
    assign has_data       = out_reg.has_data;
    assign frame_opcode   = out_reg.frame_opcode;
    assign final_fragment = out_reg.final_fragment;
    assign frame_end      = out_reg.frame_end;

    // The input stalls only behind a held byte that waits on a stalled result.
    `WSD_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> (step.valid && out_valid_reg && out_stall), "input stalled without a stalled result")
    // A stalled result stays valid.
    `WSD_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result lost")
    // A stalled result keeps its payload.
    `WSD_ASSERT(a_out_keep, clk, rst_n, (out_valid && out_stall) |=> $stable(out_reg), "result changed")

endmodule

`default_nettype wire

>>> tb/wsd_stream_checker.sv
// Stream checker for the WebSocket frame deframer: watches both channels,
// predicts each result from the accepted bytes and compares in order.
// Depends on wsd_pkg for the parser phases and length codes.

module wsd_stream_checker
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  payload_byte,
    input  logic        has_data,
    input  logic [3:0]  frame_opcode,
    input  logic        final_fragment,
    input  logic        frame_end,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned result_count,
    output int unsigned frame_count
);

    localparam int unsigned MAX_REPORTS = 40;
    localparam int unsigned EXP_DEPTH   = 256;

    // One deframed result as the block should present it.
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } deframed_t;

    // Ring of expected results, written at exp_wr and read at exp_rd.
    deframed_t   expected_results [EXP_DEPTH];
    int unsigned exp_wr;
    int unsigned exp_rd;
    deframed_t   want;
    bit          bad;

    // Parser state of the prediction.
    phase_t      phase;
    logic        fin_q;
    logic [3:0]  opcode_q;
    logic        masked_q;
    logic [3:0]  hdr_left;
    logic [63:0] remaining;
    logic [31:0] key;
    logic [1:0]  key_pos;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        result_count = 0;
        frame_count  = 0;
        exp_wr       = 0;
        exp_rd       = 0;
    end

    task automatic push_result(input logic [7:0] data, input logic has, input logic last);
        expected_results[exp_wr % EXP_DEPTH] = '{data, has, opcode_q, fin_q, last};
        exp_wr++;
    endtask

    // The length is complete: go to the key, the payload, or close an empty frame.
    task automatic length_done();
        if (masked_q)
        begin
            hdr_left = KEY_BYTES;
            key      = '0;
            phase    = PH_KEY;
        end
        else if (remaining == 0)
        begin
            push_result(8'h00, 1'b0, 1'b1);
            phase = PH_HDR1;
        end
        else
        begin
            key_pos = '0;
            phase   = PH_DATA;
        end
    endtask

    // Advance the predicted parser by one accepted stream byte.
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] d;
        case (phase)
            PH_HDR2:
            begin
                masked_q  = b[7];
                remaining = '0;
                if (b[6:0] == LEN_EXT16)
                begin
                    hdr_left = EXT16_BYTES;
                    phase    = PH_EXT;
                end
                else if (b[6:0] == LEN_EXT64)
                begin
                    hdr_left = EXT64_BYTES;
                    phase    = PH_EXT;
                end
                else
                begin
                    remaining = 64'(b[6:0]);
                    length_done();
                end
            end
            PH_EXT:
            begin
                remaining = {remaining[55:0], b};
                hdr_left  = hdr_left - 4'd1;
                if (hdr_left == 0)
                    length_done();
            end
            PH_KEY:
            begin
                key      = {key[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 0)
                begin
                    key_pos = '0;
                    if (remaining == 0)
                    begin
                        push_result(8'h00, 1'b0, 1'b1);
                        phase = PH_HDR1;
                    end
                    else
                        phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                d = masked_q ? (b ^ key[8 * (3 - int'(key_pos)) +: 8]) : b;
                key_pos   = key_pos + 2'd1;
                remaining = remaining - 64'd1;
                push_result(d, 1'b1, remaining == 0);
                if (remaining == 0)
                    phase = PH_HDR1;
            end
            default:
            begin
                fin_q    = b[7];
                opcode_q = b[3:0];
                phase    = PH_HDR2;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v, inout bit mismatch);
        if (exp_v !== act_v)
        begin
            mismatch = 1'b1;
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Predict on each input transfer, compare on each output transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            phase     = PH_HDR1;
            fin_q     = 1'b0;
            opcode_q  = '0;
            masked_q  = 1'b0;
            hdr_left  = '0;
            remaining = '0;
            key       = '0;
            key_pos   = '0;
            exp_wr    = 0;
            exp_rd    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (exp_wr == exp_rd)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual byte %0h end %0b",
                                 $time, payload_byte, frame_end);
                    fail_count++;
                end
                else
                begin
                    want = expected_results[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    bad  = 1'b0;
                    check_field("payload_byte", want.data, payload_byte, bad);
                    check_field("has_data", 8'(want.has_data), 8'(has_data), bad);
                    check_field("frame_opcode", 8'(want.opcode), 8'(frame_opcode), bad);
                    check_field("final_fragment", 8'(want.fin), 8'(final_fragment), bad);
                    check_field("frame_end", 8'(want.last), 8'(frame_end), bad);
                    if (bad)
                        fail_count++;
                    if (want.last)
                        frame_count++;
                end
            end
        end
        pending = exp_wr - exp_rd;
    end

endmodule

>>> tb/tb_top.sv
// Top of the deframer testbench: clock, reset, byte stream stimulus and verdict.
// Depends on wsd_pkg, websocket_frame_deframer and wsd_stream_checker.

module tb_top;
    import wsd_pkg::*;

    localparam int unsigned STREAM_BYTES = 480;
    localparam int unsigned QUIET_FROM   = 400;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // How a frame encodes its payload length.
    typedef enum logic [1:0] {LEN_SHORT, LEN_16, LEN_64} len_form_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  payload_byte;
    logic        has_data;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        frame_end;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned result_count;
    int unsigned frame_count;

    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned gap_rate;
    int unsigned out_pressure;
    bit          quiet;

    websocket_frame_deframer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .has_data       (has_data),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .frame_end      (frame_end)
    );

    wsd_stream_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .has_data       (has_data),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .frame_end      (frame_end),
        .fail_count     (fail_count),
        .pending        (pending),
        .result_count   (result_count),
        .frame_count    (frame_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #400000;
        $display("websocket_frame_deframer regression: fail");
        $finish;
    end

    // Receiver side: random stall bursts whose density follows out_pressure.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (out_pressure != 0 && $urandom_range(0, 15) < out_pressure)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Offer one byte and hold it until its transfer; called at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        if (gap_rate != 0 && $urandom_range(0, 15) < gap_rate)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Send one frame; n_data may be below len to leave a frame open.
    // A negative fill gives random payload bytes.
    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opcode,
                              input logic masked, input len_form_t form,
                              input logic [63:0] len, input int n_data,
                              input logic [31:0] key, input int fill);
        logic [6:0] len7;
        len7 = (form == LEN_SHORT) ? len[6:0] : ((form == LEN_16) ? LEN_EXT16 : LEN_EXT64);
        send_byte({fin, rsv, opcode});
        send_byte({masked, len7});
        if (form == LEN_16)
        begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else if (form == LEN_64)
        begin
            for (int i = 7; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        end
        if (masked)
        begin
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        end
        for (int i = 0; i < n_data; i++)
            send_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
        frames_sent++;
    endtask

    // Stimulus and verdict.
    initial
    begin
        int unsigned pick;
        int unsigned waited;
        logic [63:0] len;
        len_form_t   form;
        logic [3:0]  opcode;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        bytes_sent   = 0;
        frames_sent  = 0;
        gap_rate     = 0;
        out_pressure = 0;
        quiet        = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames: empty unmasked and masked frames, reserved bits set,
        // extreme payload and key values, and a zero length in the 16-bit form.
        send_frame(1'b1, 3'b000, OP_PING, 1'b0, LEN_SHORT, 64'd0, 0, 32'h0, -1);
        send_frame(1'b0, 3'b111, OP_PONG, 1'b1, LEN_SHORT, 64'd0, 0, 32'h0000_0000, -1);
        send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, LEN_SHORT, 64'd2, 2, 32'h0, 8'hFF);
        send_frame(1'b0, 3'b000, OP_BINARY, 1'b1, LEN_SHORT, 64'd5, 5, 32'hFFFF_FFFF, 8'h00);
        send_frame(1'b1, 3'b000, 4'hF, 1'b0, LEN_16, 64'd0, 0, 32'h0, -1);

        // Random frames, mostly with standard opcodes, all length forms.
        while (bytes_sent < STREAM_BYTES)
        begin
            quiet        = (bytes_sent >= QUIET_FROM);
            gap_rate     = quiet ? 0 : $urandom_range(0, 4);
            out_pressure = quiet ? 0 : $urandom_range(0, 4);
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                form = LEN_SHORT;
                len  = 64'($urandom_range(0, 20));
            end
            else if (pick < 72)
            begin
                form = LEN_SHORT;
                len  = 64'($urandom_range(21, 125));
            end
            else if (pick < 84)
            begin
                form = LEN_16;
                len  = 64'($urandom_range(0, 300));
            end
            else
            begin
                form = LEN_64;
                len  = 64'($urandom_range(0, 40));
            end
            case ($urandom_range(0, 9))
                0: opcode = OP_CONT;
                1: opcode = OP_TEXT;
                2: opcode = OP_BINARY;
                3: opcode = OP_CLOSE;
                4: opcode = OP_PING;
                5: opcode = OP_PONG;
                default: opcode = 4'($urandom_range(0, 15));
            endcase
            send_frame(1'($urandom), 3'($urandom), opcode, $urandom_range(0, 3) != 0,
                       form, len, int'(len), $urandom, -1);
        end

        // A 64-bit length with its top bit set; the frame stays open to the end.
        quiet        = 1'b1;
        gap_rate     = 0;
        out_pressure = 0;
        send_frame(1'b1, 3'b000, OP_BINARY, 1'b1, LEN_64, 64'h8000_0000_0000_0003, 40,
                   $urandom, -1);
        in_valid = 1'b0;

        waited = 0;
        while (pending != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);

        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        $display("Streamed %0d bytes in %0d frames, all length forms, masked and unmasked.",
                 bytes_sent, frames_sent);
        $display("Checked %0d results, %0d of them closing a frame.", result_count, frame_count);
        if (fail_count == 0 && pending == 0)
            $display("websocket_frame_deframer regression: pass");
        else
            $display("websocket_frame_deframer regression: fail");
        $finish;
    end

endmodule
